// File: rtl/fcrg_pkg.sv
// ----------------------------------------------------------------------------
// fcrg_pkg
// Shared types and constants of the frame counter replay guard.
// ----------------------------------------------------------------------------
package fcrg_pkg;

  // counter width and the first value that may no longer be bumped
  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_LIMIT = 32'hFFFF_FFFE;

  // configuration register indexes
  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_START = 1'b1;

  // request commands
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_NEXT    = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NO_RESTORE = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// File: rtl/frame_counter_replay_guard_unit.sv
// ----------------------------------------------------------------------------
// frame_counter_replay_guard_unit
// Link-layer frame counter engine with a per-neighbor table: init, next
// outgoing counter, replay check and counter restore.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                    | tuser
//  --------+-----------+---------------------------------------+---------------
//  in_     | slave     | neighbor, rx_counter, counter_low_byte | command, is_broadcast
//  out_    | master    | counter_out, replayed                  | status
//  cfg_    | write     | index 0 per_neighbor_mode, 1 unicast_counter_start
//
//  a request is accepted (table read issued) and then executed in the EXEC state,
//  once the registered read of the neighbor RAMs is back
//  a new request is taken while a result still waits in the output register;
//  execute stalls only while that register is full and out_tready is low
//  synchronous active-low reset clears control, config and the shared counter;
//  the neighbor tables are not cleared, an entry is valid once init wrote it
//
module frame_counter_replay_guard_unit #(
  parameter int NEIGHBOR_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // neighbor[3:0], rx_counter[35:4],
                                  // counter_low_byte[43:36], zero[47:44]
  input  logic [2:0]  in_tuser,   // command[1:0], is_broadcast[2]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // counter_out[31:0], replayed[32], zero[39:33]
  output logic [1:0]  out_tuser,  // status[1:0]
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  fcrg_pkg::ctl_t ctl;
  fcrg_pkg::sts_t sts;
  logic [31:0]    counter_out;
  logic           replayed;

  fcrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  fcrg_datapath #(.NEIGHBOR_COUNT(NEIGHBOR_COUNT)) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_tuser[1:0]),
    .in_neighbor         (in_tdata[3:0]),
    .in_is_broadcast     (in_tuser[2]),
    .in_rx_counter       (in_tdata[35:4]),
    .in_counter_low_byte (in_tdata[43:36]),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_counter         (counter_out),
    .out_replayed        (replayed),
    .out_status          (out_tuser)
  );

  // result packing
  assign out_tdata = {7'b0, replayed, counter_out};

endmodule

// File: rtl/fcrg_ram.sv
// ----------------------------------------------------------------------------
// fcrg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fcrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fcrg_ctrl.sv
// ----------------------------------------------------------------------------
// fcrg_ctrl
// Controller: takes a request, waits for the table read, then executes it
// once the result register is free or is being drained.
// ----------------------------------------------------------------------------
module fcrg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_tready,
  input  fcrg_pkg::sts_t      sts,
  output fcrg_pkg::ctl_t      ctl
);

  fcrg_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcrg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    unique case (state_r)
      fcrg_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = fcrg_pkg::S_EXEC;
        end
      end
      fcrg_pkg::S_EXEC: begin
        if (!sts.out_full || out_tready) begin
          ctl.exec  = 1'b1;
          state_nxt = fcrg_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

// File: rtl/fcrg_datapath.sv
// ----------------------------------------------------------------------------
// fcrg_datapath
// Datapath: request registers, neighbor tables, shared counter, config
// registers and the result register.
// ----------------------------------------------------------------------------
module fcrg_datapath #(
  parameter int NEIGHBOR_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcrg_pkg::ctl_t               ctl,
  output fcrg_pkg::sts_t               sts,
  // config port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [fcrg_pkg::CNT_W-1:0]   cfg_wdata,
  // request fields
  input  logic [1:0]                   in_command,
  input  logic [3:0]                   in_neighbor,
  input  logic                         in_is_broadcast,
  input  logic [fcrg_pkg::CNT_W-1:0]   in_rx_counter,
  input  logic [7:0]                   in_counter_low_byte,
  // result
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [fcrg_pkg::CNT_W-1:0]   out_counter,
  output logic                         out_replayed,
  output logic [1:0]                   out_status
);

  localparam int AW = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
  localparam logic [10:0] NB_LIMIT = 11'(NEIGHBOR_COUNT);

  // request registers
  fcrg_pkg::cmd_t              cmd_r;
  logic [3:0]                  nb_r;
  logic                        bcast_r;
  logic [fcrg_pkg::CNT_W-1:0]  rx_r;
  logic [7:0]                  lsb_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= fcrg_pkg::cmd_t'(in_command);
      nb_r    <= in_neighbor;
      bcast_r <= in_is_broadcast;
      rx_r    <= in_rx_counter;
      lsb_r   <= in_counter_low_byte;
    end
  end

  // config registers
  logic                        mode_r;
  logic [fcrg_pkg::CNT_W-1:0]  start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcrg_pkg::CFG_IDX_MODE:  mode_r  <= cfg_wdata[0];
        fcrg_pkg::CFG_IDX_START: start_r <= cfg_wdata;
      endcase
    end
  end

  // neighbor tables, read at capture and held on the captured entry, written at execute
  logic [AW-1:0]               raddr, waddr;
  logic [fcrg_pkg::CNT_W-1:0]  rd_tx, rd_lb, rd_lu;
  logic [fcrg_pkg::CNT_W-1:0]  wd_tx, wd_lb, wd_lu;
  logic                        we_tx, we_lb, we_lu;

  assign raddr = ctl.capture ? AW'(in_neighbor) : AW'(nb_r);
  assign waddr = AW'(nb_r);

  fcrg_ram #(.WIDTH(fcrg_pkg::CNT_W), .DEPTH(NEIGHBOR_COUNT)) u_tx_unicast (
    .clk(clk), .we(we_tx), .waddr(waddr), .wdata(wd_tx), .raddr(raddr), .rdata(rd_tx)
  );

  fcrg_ram #(.WIDTH(fcrg_pkg::CNT_W), .DEPTH(NEIGHBOR_COUNT)) u_last_bcast (
    .clk(clk), .we(we_lb), .waddr(waddr), .wdata(wd_lb), .raddr(raddr), .rdata(rd_lb)
  );

  fcrg_ram #(.WIDTH(fcrg_pkg::CNT_W), .DEPTH(NEIGHBOR_COUNT)) u_last_ucast (
    .clk(clk), .we(we_lu), .waddr(waddr), .wdata(wd_lu), .raddr(raddr), .rdata(rd_lu)
  );

  // shared outgoing counter
  logic [fcrg_pkg::CNT_W-1:0]  shared_r, shared_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_r <= '0;
    end else begin
      shared_r <= shared_nxt;
    end
  end

  // command execution
  logic                        nb_ok, use_shared, exh;
  logic [fcrg_pkg::CNT_W-1:0]  last_sel, old_cnt, inc_cnt;
  logic [23:0]                 upper;
  logic [fcrg_pkg::CNT_W-1:0]  cout;
  logic                        rep;
  fcrg_pkg::status_t           st;

  assign nb_ok      = {7'b0, nb_r} < NB_LIMIT;
  assign use_shared = !mode_r || bcast_r;
  assign last_sel   = bcast_r ? rd_lb : rd_lu;
  assign old_cnt    = use_shared ? shared_r : rd_tx;
  assign exh        = old_cnt >= fcrg_pkg::CNT_LIMIT;
  assign inc_cnt    = old_cnt + 32'd1;
  assign upper      = last_sel[31:8] + {23'b0, (lsb_r < last_sel[7:0])};

  always_comb begin
    shared_nxt = shared_r;
    we_tx      = 1'b0;
    we_lb      = 1'b0;
    we_lu      = 1'b0;
    wd_tx      = inc_cnt;
    wd_lb      = rx_r;
    wd_lu      = rx_r;
    cout       = '0;
    rep        = 1'b0;
    st         = fcrg_pkg::ST_OK;
    unique case (cmd_r)
      fcrg_pkg::CMD_INIT: begin
        wd_tx = mode_r ? start_r : '0;
        wd_lb = '0;
        wd_lu = '0;
        if (nb_ok) begin
          we_tx = 1'b1;
          we_lb = 1'b1;
          we_lu = 1'b1;
        end
      end
      fcrg_pkg::CMD_NEXT: begin
        if (use_shared || nb_ok) begin
          if (exh) begin
            st = fcrg_pkg::ST_EXHAUSTED;
          end else begin
            cout = inc_cnt;
            if (use_shared) begin
              shared_nxt = inc_cnt;
            end else begin
              we_tx = 1'b1;
            end
          end
        end
      end
      fcrg_pkg::CMD_CHECK: begin
        if (nb_ok) begin
          if (rx_r <= last_sel) begin
            rep = 1'b1;
          end else if (bcast_r) begin
            we_lb = 1'b1;
          end else begin
            we_lu = 1'b1;
          end
        end
      end
      fcrg_pkg::CMD_RESTORE: begin
        if (!mode_r) begin
          st = fcrg_pkg::ST_NO_RESTORE;
        end else if (nb_ok) begin
          cout = {upper, lsb_r};
        end
      end
    endcase
    // state only changes on the execute cycle
    if (!ctl.exec) begin
      shared_nxt = shared_r;
      we_tx      = 1'b0;
      we_lb      = 1'b0;
      we_lu      = 1'b0;
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_counter  <= cout;
      out_replayed <= rep;
      out_status   <= st;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.out_full = out_valid_r;

  // checks on the datapath
  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still held");

  a_replay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_replayed |-> out_status == fcrg_pkg::ST_OK && out_counter == '0)
    else $error("replayed result carries a counter or a status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status != fcrg_pkg::ST_OK |-> out_counter == '0)
    else $error("failed request returned a nonzero counter");

  a_shared_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(ctl.exec) && $past(rst_n) |-> $stable(shared_r))
    else $error("shared counter changed outside execute");

endmodule
